/* design/fce_pkg.sv */
// Shared types and constants for the edge-replicating FIR convolution block.
// No dependencies; every other file imports this package.
package fce_pkg;

    localparam int COEF_BITS = 16;
    localparam int OUT_BITS  = 37;
    localparam int CFG_BITS  = 6;
    localparam int IDX_BITS  = 5;

    // Command codes carried by an input beat
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Controls broadcast to every history cell
    typedef struct packed {
        logic fill;   // load every cell with the fill value
        logic shift;  // history moves one cell toward the old end
        logic load;   // copy history into the scan chain
        logic scan;   // scan chain moves one cell toward cell 0
    } t_cell_ctl;

    // Controls for the multiply-accumulate unit
    typedef struct packed {
        logic clr;    // start a new sum
        logic en;     // coefficient and sample inputs are valid
    } t_mac_ctl;

endpackage

/* design/fce_if.sv */
// Handshake channels of the FIR convolution block: input items, results
// and the tap count write port. Uses fce_pkg for field widths.
interface fce_in_if import fce_pkg::*; #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [IDX_BITS-1:0]           coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          frame_end;

    modport source (output valid, command, coef_index, coef_value, sample_value, frame_end,
                    input ready);
    modport sink   (input valid, command, coef_index, coef_value, sample_value, frame_end,
                    output ready);
endinterface

interface fce_out_if import fce_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] filtered_value;
    logic                       frame_done;

    modport source (output valid, filtered_value, frame_done, input ready);
    modport sink   (input valid, filtered_value, frame_done, output ready);
endinterface

interface fce_cfg_if import fce_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* design/fce_cell.sv */
// One history cell: a sample of the shift history plus one scan-chain stage.
// Depends on fce_pkg for the broadcast control struct.
module fce_cell import fce_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_fill_value,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_hist,
    input  logic signed [SAMPLE_BITS-1:0] i_next_scan,
    output logic signed [SAMPLE_BITS-1:0] o_hist,
    output logic signed [SAMPLE_BITS-1:0] o_scan
);

    logic signed [SAMPLE_BITS-1:0] r_hist;
    logic signed [SAMPLE_BITS-1:0] r_scan;

    // Hold, fill or take the neighbor's sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_ctl.fill) begin
            r_hist <= i_fill_value;
        end else if (i_ctl.shift) begin
            r_hist <= i_prev_hist;
        end
    end

    // Capture the history or pass the scan toward the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_scan <= r_hist;
        end else if (i_ctl.scan) begin
            r_scan <= i_next_scan;
        end
    end

    assign o_hist = r_hist;
    assign o_scan = r_scan;

endmodule

/* design/fce_mac.sv */
// Multiply-accumulate unit: registered product, then full-precision sum.
// Depends on fce_pkg for coefficient and output widths.
module fce_mac import fce_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [OUT_BITS-1:0]    o_acc
);

    localparam int PW    = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W = (PW >= OUT_BITS) ? PW + 1 : OUT_BITS + 1;

    logic signed [PW-1:0]    r_prod;
    logic                    r_pv;
    logic signed [ACC_W-1:0] r_acc;

    // Register the product
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= i_coef * i_sample;
        end
    end

    // Track product valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.en;
        end
    end

    // Accumulate; the low bits wrap exactly as the output does
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + {{(ACC_W-PW){r_prod[PW-1]}}, r_prod};
        end
    end

    assign o_acc = r_acc[OUT_BITS-1:0];

endmodule

/* design/fir_conv_edge_replicate.sv */
// Centered FIR convolution with edge replication; coefficient loads are stored on accept.
// Per sample, each history step (1, or 1 + lag on frame end) runs shift, advance with no
// result, or shift, load, scan of m taps in use, drain, output (held until taken), advance:
// the single multiply-accumulate unit walks the scan chain of cells one tap per cycle.
// Reset (synchronous, active low) clears control, closes any frame, sets tap count
// to 1 and zeroes the history cells; the coefficient store is not cleared.
module fir_conv_edge_replicate import fce_pkg::*; #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fce_in_if.sink     i_sample,
    fce_cfg_if.sink    i_cfg,
    fce_out_if.source  o_result
);

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_ADV   = 3'd6;

    // Reduce a coefficient index modulo the store depth, one compare a bit
    function automatic logic [IW-1:0] wrap_idx(input logic [IDX_BITS-1:0] v);
        int r;
        r = int'(v);
        for (int b = IDX_BITS - 1; b >= 0; b--) begin
            if (r >= (MAX_TAPS << b)) begin
                r = r - (MAX_TAPS << b);
            end
        end
        return IW'(r);
    endfunction

    logic [2:0]                    r_state, n_state;
    logic [CFG_BITS-1:0]           r_tap;
    logic                          r_started, n_started;
    logic [CW-1:0]                 r_pos, n_pos;
    logic [CW-1:0]                 r_m, n_m;
    logic [CW-1:0]                 r_lag, n_lag;
    logic [CW-1:0]                 r_left, n_left;
    logic [CW-1:0]                 r_k, n_k;
    logic signed [SAMPLE_BITS-1:0] r_s, n_s;
    logic                          r_fe, n_fe;
    logic                          r_ovalid, n_ovalid;
    logic signed [OUT_BITS-1:0]    r_oval, n_oval;
    logic                          r_odone, n_odone;
    logic signed [COEF_BITS-1:0]   r_rd;
    logic signed [COEF_BITS-1:0]   r_kernel [MAX_TAPS];

    logic                          in_beat;
    logic [CW-1:0]                 m_c;
    logic [CW-1:0]                 lag_c;
    logic [CW-1:0]                 rd_full;
    t_cell_ctl                     cell_ctl;
    t_mac_ctl                      mac_ctl;
    logic signed [OUT_BITS-1:0]    acc;
    logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] scan [MAX_TAPS];

    assign i_sample.ready = (r_state == S_IDLE);
    assign in_beat        = i_sample.valid && i_sample.ready;
    assign i_cfg.ready    = 1'b1;

    // Clamp the tap count and derive the output lag
    always_comb begin
        if (r_tap == '0) begin
            m_c = CW'(1);
        end else if (r_tap > MAX_TAPS) begin
            m_c = CW'(MAX_TAPS);
        end else begin
            m_c = CW'(r_tap);
        end
        lag_c = m_c - CW'(1) - (m_c >> 1);
    end

    // Sequence each history step: shift, then, once r_pos reaches the lag, scan the kernel and deliver
    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_pos     = r_pos;
        n_m       = r_m;
        n_lag     = r_lag;
        n_left    = r_left;
        n_k       = r_k;
        n_s       = r_s;
        n_fe      = r_fe;
        n_ovalid  = r_ovalid && !o_result.ready;
        n_oval    = r_oval;
        n_odone   = r_odone;
        cell_ctl  = '0;
        mac_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat && i_sample.command == CMD_SAMPLE) begin
                    n_m     = m_c;
                    n_lag   = lag_c;
                    n_s     = i_sample.sample_value;
                    n_fe    = i_sample.frame_end;
                    n_left  = i_sample.frame_end ? lag_c : '0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!r_started) begin
                    cell_ctl.fill = 1'b1;
                    n_started     = 1'b1;
                end else begin
                    cell_ctl.shift = 1'b1;
                end
                n_state = (r_pos >= r_lag) ? S_LOAD : S_ADV;
            end
            S_LOAD: begin
                cell_ctl.load = 1'b1;
                mac_ctl.clr   = 1'b1;
                n_k           = '0;
                n_state       = S_MAC;
            end
            S_MAC: begin
                cell_ctl.scan = 1'b1;
                mac_ctl.en    = 1'b1;
                n_k           = r_k + CW'(1);
                if (r_k == r_m - CW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_result.ready) begin
                    n_ovalid = 1'b1;
                    n_oval   = acc;
                    n_odone  = r_fe && (r_left == '0);
                    n_state  = S_ADV;
                end
            end
            S_ADV: begin
                if (r_pos < CW'(MAX_TAPS)) begin
                    n_pos = r_pos + CW'(1);
                end
                if (r_left != '0) begin
                    n_left  = r_left - CW'(1);
                    n_state = S_SHIFT;
                end else begin
                    if (r_fe) begin
                        n_started = 1'b0;
                        n_pos     = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_pos     <= '0;
            r_ovalid  <= 1'b0;
            r_tap     <= CFG_BITS'(1);
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_pos     <= n_pos;
            r_ovalid  <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_tap <= i_cfg.data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_m     <= n_m;
        r_lag   <= n_lag;
        r_left  <= n_left;
        r_k     <= n_k;
        r_s     <= n_s;
        r_fe    <= n_fe;
        r_oval  <= n_oval;
        r_odone <= n_odone;
    end

    // Coefficient address: top tap first, walking down one per scan cycle
    assign rd_full = (r_state == S_LOAD) ? (r_m - CW'(1)) : (r_m - CW'(2) - r_k);

    // Coefficient store: write on a load beat, registered read
    always_ff @(posedge i_clk) begin
        if (in_beat && i_sample.command == CMD_LOAD) begin
            r_kernel[wrap_idx(i_sample.coef_index)] <= i_sample.coef_value;
        end
        r_rd <= r_kernel[rd_full[IW-1:0]];
    end

    // Row of history cells; cell 0 holds the newest sample
    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] prev_hist;
        logic signed [SAMPLE_BITS-1:0] next_scan;
        if (g == 0) begin : g_head
            assign prev_hist = r_s;
        end else begin : g_body
            assign prev_hist = hist[g-1];
        end
        if (g == MAX_TAPS - 1) begin : g_tail
            assign next_scan = '0;
        end else begin : g_link
            assign next_scan = scan[g+1];
        end
        fce_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_fill_value (r_s),
            .i_prev_hist  (prev_hist),
            .i_next_scan  (next_scan),
            .o_hist       (hist[g]),
            .o_scan       (scan[g])
        );
    end

    fce_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_coef   (r_rd),
        .i_sample (scan[0]),
        .o_acc    (acc)
    );

    assign o_result.valid          = r_ovalid;
    assign o_result.filtered_value = r_oval;
    assign o_result.frame_done     = r_odone;

endmodule
